@@ sv/nwus_pkg.sv @@
// Shared types and constants of the number-with-uncertainty scanner.
package nwus_pkg;

    localparam int CHAR_W  = 8;
    localparam int VAL_W   = 64;
    localparam int EXP_W   = 32;
    localparam int POW_W   = 34;
    localparam int CNT_W   = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_TOKEN_LEN = 16'hFFFF;
    localparam logic [EXP_W-1:0] EXP_CAP       = 32'h1000_0000;

    // Character classes produced by the front end.
    localparam logic [2:0] CLS_DIGIT  = 3'd0;
    localparam logic [2:0] CLS_DOT    = 3'd1;
    localparam logic [2:0] CLS_MINUS  = 3'd2;
    localparam logic [2:0] CLS_PLUS   = 3'd3;
    localparam logic [2:0] CLS_EXP    = 3'd4;
    localparam logic [2:0] CLS_LPAREN = 3'd5;
    localparam logic [2:0] CLS_RPAREN = 3'd6;
    localparam logic [2:0] CLS_OTHER  = 3'd7;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

@@ sv/nwus_ifs.sv @@
// Handshake interfaces for the character and result channels.
interface nwus_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface nwus_res_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic               negative;
    logic [63:0]        mantissa;
    logic signed [33:0] power_of_ten;
    logic [63:0]        uncertainty;
    logic [15:0]        int_digit_count;
    logic [15:0]        frac_digit_count;
    logic [15:0]        unc_digit_count;
    logic [15:0]        stop_position;

    modport source (
        output valid, output valid_res, output negative, output mantissa,
        output power_of_ten, output uncertainty, output int_digit_count,
        output frac_digit_count, output unc_digit_count, output stop_position,
        input ready
    );
    modport sink (
        input valid, input valid_res, input negative, input mantissa,
        input power_of_ten, input uncertainty, input int_digit_count,
        input frac_digit_count, input unc_digit_count, input stop_position,
        output ready
    );
endinterface

@@ sv/nwus_front.sv @@
// Front end: classify each incoming character and queue it for the scanner.
module nwus_front
    import nwus_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    nwus_char_if.sink        chars,
    output q_head_t          head,
    input  logic             pop
);

    entry_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    entry_t              new_entry;

    function automatic logic [2:0] classify(input logic [CHAR_W-1:0] c);
        logic [2:0] cls;
        if (c >= "0" && c <= "9")
            cls = CLS_DIGIT;
        else if (c == ".")
            cls = CLS_DOT;
        else if (c == "-")
            cls = CLS_MINUS;
        else if (c == "+")
            cls = CLS_PLUS;
        else if (c == "e" || c == "E")
            cls = CLS_EXP;
        else if (c == "(")
            cls = CLS_LPAREN;
        else if (c == ")")
            cls = CLS_RPAREN;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    assign chars.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push        = chars.valid && chars.ready;

    always_comb
    begin
        new_entry.cls   = classify(chars.character);
        new_entry.digit = chars.character[3:0];
        new_entry.last  = chars.final_char;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_entry;
    end

endmodule

@@ sv/nwus_back.sv @@
// Back end: token scanner state machine and registered result stage.
module nwus_back
    import nwus_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    output logic       pop,
    nwus_res_if.source results
);

    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_INT      = 3'd1;
    localparam logic [2:0] PH_FRAC     = 3'd2;
    localparam logic [2:0] PH_EXP_E    = 3'd3;
    localparam logic [2:0] PH_EXP_SIGN = 3'd4;
    localparam logic [2:0] PH_EXP_DIG  = 3'd5;
    localparam logic [2:0] PH_UNC      = 3'd6;
    localparam logic [2:0] PH_DONE     = 3'd7;

    logic [2:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic             exp_neg_reg, exp_neg_next;
    logic [VAL_W-1:0] unc_reg, unc_next;
    logic [CNT_W-1:0] int_cnt_reg, int_cnt_next;
    logic [CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic [CNT_W-1:0] unc_cnt_reg, unc_cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] e_idx_reg, e_idx_next;
    logic [CNT_W-1:0] stop_reg, stop_next;
    logic             failed_reg, failed_next;

    logic             res_valid_reg;
    logic             res_ok_reg;
    logic             res_neg_reg;
    logic [VAL_W-1:0] res_mant_reg;
    logic [POW_W-1:0] res_pow_reg;
    logic [VAL_W-1:0] res_unc_reg;
    logic [CNT_W-1:0] res_int_reg;
    logic [CNT_W-1:0] res_frac_reg;
    logic [CNT_W-1:0] res_ucnt_reg;
    logic [CNT_W-1:0] res_stop_reg;

    logic [2:0]       cls;
    logic             last;
    logic             is_dig;
    logic [VAL_W-1:0] value_mul;
    logic [VAL_W-1:0] unc_mul;
    logic [EXP_W-1:0] exp_mul;
    logic [2:0]       ph;
    logic             skip;
    logic             none_yet;
    logic             ok;
    logic [CNT_W-1:0] stop_fin;
    logic [POW_W-1:0] exp_ext;
    logic [POW_W-1:0] exp_signed;
    logic [POW_W-1:0] pow_fin;

    assign cls    = head.entry.cls;
    assign last   = head.entry.last;
    assign is_dig = (cls == CLS_DIGIT);

    // Times ten plus digit, as shifts and adds.
    assign value_mul = (value_reg << 3) + (value_reg << 1) + VAL_W'(head.entry.digit);
    assign unc_mul   = (unc_reg << 3) + (unc_reg << 1) + VAL_W'(head.entry.digit);
    assign exp_mul   = (exp_reg << 3) + (exp_reg << 1) + EXP_W'(head.entry.digit);

    assign none_yet = (int_cnt_reg == '0) && (frac_cnt_reg == '0);

    // A final character needs the result slot; others never wait on it.
    assign pop = head.valid && (!last || !res_valid_reg || results.ready);

    always_comb
    begin
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        value_next    = value_reg;
        exp_next      = exp_reg;
        exp_neg_next  = exp_neg_reg;
        unc_next      = unc_reg;
        int_cnt_next  = int_cnt_reg;
        frac_cnt_next = frac_cnt_reg;
        unc_cnt_next  = unc_cnt_reg;
        idx_next      = idx_reg;
        e_idx_next    = e_idx_reg;
        stop_next     = stop_reg;
        failed_next   = failed_reg;
        ph            = phase_reg;
        skip          = 1'b0;

        if (idx_reg == MAX_TOKEN_LEN)
        begin
            failed_next = 1'b1;
        end
        else
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (!failed_reg)
            begin
                if (phase_reg == PH_START)
                begin
                    phase_next = PH_INT;
                    ph         = PH_INT;
                    if (cls == CLS_MINUS)
                    begin
                        neg_next = 1'b1;
                        skip     = 1'b1;
                    end
                    else if (cls == CLS_PLUS)
                    begin
                        skip = 1'b1;
                    end
                end
                if (!skip)
                begin
                    unique case (ph)
                        PH_INT, PH_FRAC:
                        begin
                            if (is_dig)
                            begin
                                value_next = value_mul;
                                if (ph == PH_INT)
                                    int_cnt_next = int_cnt_reg + CNT_W'(1);
                                else
                                    frac_cnt_next = frac_cnt_reg + CNT_W'(1);
                            end
                            else if (ph == PH_INT && cls == CLS_DOT)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else if (none_yet)
                            begin
                                failed_next = 1'b1;
                            end
                            else if (cls == CLS_EXP)
                            begin
                                e_idx_next = idx_reg;
                                phase_next = PH_EXP_E;
                            end
                            else if (cls == CLS_LPAREN)
                            begin
                                phase_next = PH_UNC;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                stop_next  = idx_reg;
                            end
                        end
                        PH_EXP_E, PH_EXP_SIGN, PH_EXP_DIG:
                        begin
                            if (ph == PH_EXP_E && cls == CLS_MINUS)
                            begin
                                exp_neg_next = 1'b1;
                                phase_next   = PH_EXP_SIGN;
                            end
                            else if (ph == PH_EXP_E && cls == CLS_PLUS)
                            begin
                                phase_next = PH_EXP_SIGN;
                            end
                            else if (is_dig)
                            begin
                                // Stop growing once the cap is reached.
                                if (exp_reg < EXP_CAP)
                                    exp_next = exp_mul;
                                phase_next = PH_EXP_DIG;
                            end
                            else if (ph == PH_EXP_DIG && cls == CLS_LPAREN)
                            begin
                                phase_next = PH_UNC;
                            end
                            else if (ph == PH_EXP_DIG)
                            begin
                                phase_next = PH_DONE;
                                stop_next  = idx_reg;
                            end
                            else
                            begin
                                // No exponent digit: back off to the 'e'.
                                phase_next = PH_DONE;
                                stop_next  = e_idx_reg;
                            end
                        end
                        PH_UNC:
                        begin
                            if (is_dig)
                            begin
                                unc_next     = unc_mul;
                                unc_cnt_next = unc_cnt_reg + CNT_W'(1);
                            end
                            else if (cls == CLS_RPAREN)
                            begin
                                phase_next = PH_DONE;
                                stop_next  = idx_reg + CNT_W'(1);
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Done: ignore the rest of the token.
                        end
                    endcase
                end
            end
        end
    end

    // End-of-token evaluation on the updated state.
    always_comb
    begin
        ok       = !failed_next;
        stop_fin = stop_next;
        unique case (phase_next) inside
            PH_INT, PH_FRAC:
            begin
                if (int_cnt_next == '0 && frac_cnt_next == '0)
                    ok = 1'b0;
                else
                    stop_fin = idx_next;
            end
            PH_EXP_E, PH_EXP_SIGN:
                stop_fin = e_idx_next;
            PH_EXP_DIG:
                stop_fin = idx_next;
            PH_DONE:
                stop_fin = stop_next;
            default:
                ok = 1'b0;
        endcase
    end

    assign exp_ext    = {{(POW_W - EXP_W){1'b0}}, exp_next};
    assign exp_signed = exp_neg_next ? (POW_W'(0) - exp_ext) : exp_ext;
    assign pow_fin    = exp_signed - {{(POW_W - CNT_W){1'b0}}, frac_cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            value_reg     <= '0;
            exp_reg       <= '0;
            exp_neg_reg   <= 1'b0;
            unc_reg       <= '0;
            int_cnt_reg   <= '0;
            frac_cnt_reg  <= '0;
            unc_cnt_reg   <= '0;
            idx_reg       <= '0;
            e_idx_reg     <= '0;
            stop_reg      <= '0;
            failed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && last)
            begin
                phase_reg     <= PH_START;
                neg_reg       <= 1'b0;
                value_reg     <= '0;
                exp_reg       <= '0;
                exp_neg_reg   <= 1'b0;
                unc_reg       <= '0;
                int_cnt_reg   <= '0;
                frac_cnt_reg  <= '0;
                unc_cnt_reg   <= '0;
                idx_reg       <= '0;
                e_idx_reg     <= '0;
                stop_reg      <= '0;
                failed_reg    <= 1'b0;
                res_valid_reg <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    phase_reg    <= phase_next;
                    neg_reg      <= neg_next;
                    value_reg    <= value_next;
                    exp_reg      <= exp_next;
                    exp_neg_reg  <= exp_neg_next;
                    unc_reg      <= unc_next;
                    int_cnt_reg  <= int_cnt_next;
                    frac_cnt_reg <= frac_cnt_next;
                    unc_cnt_reg  <= unc_cnt_next;
                    idx_reg      <= idx_next;
                    e_idx_reg    <= e_idx_next;
                    stop_reg     <= stop_next;
                    failed_reg   <= failed_next;
                end
                if (results.ready)
                    res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && last)
        begin
            res_ok_reg   <= ok;
            res_neg_reg  <= neg_next;
            res_mant_reg <= value_next;
            res_pow_reg  <= pow_fin;
            res_unc_reg  <= unc_next;
            res_int_reg  <= int_cnt_next;
            res_frac_reg <= frac_cnt_next;
            res_ucnt_reg <= unc_cnt_next;
            res_stop_reg <= stop_fin;
        end
    end

    // An invalid result shows zero in every field.
    assign results.valid            = res_valid_reg;
    assign results.valid_res        = res_ok_reg;
    assign results.negative         = res_ok_reg & res_neg_reg;
    assign results.mantissa         = res_ok_reg ? res_mant_reg : '0;
    assign results.power_of_ten     = res_ok_reg ? $signed(res_pow_reg) : '0;
    assign results.uncertainty      = res_ok_reg ? res_unc_reg : '0;
    assign results.int_digit_count  = res_ok_reg ? res_int_reg : '0;
    assign results.frac_digit_count = res_ok_reg ? res_frac_reg : '0;
    assign results.unc_digit_count  = res_ok_reg ? res_ucnt_reg : '0;
    assign results.stop_position    = res_ok_reg ? res_stop_reg : '0;

endmodule

@@ sv/number_with_uncertainty_scanner.sv @@
// Top level of the decimal number scanner with parenthesized uncertainty.
//
// Usage: feed one numeric token on the chars channel, one byte per request,
// with final_char set on the last byte. For every token exactly one result
// request appears on the results channel: valid_res, sign, 64-bit mantissa,
// signed power of ten, uncertainty, the three digit counts and the index of
// the first byte not consumed. When valid_res is 0 all other fields read 0.
//
// Throughput: one byte per cycle, sustained, tokens back to back, while the
// receiver takes results; the back-end scanner loop, a times-ten-and-add per
// byte, sets the rate. A final byte passes the queue, then the result register.
//
// The front end classifies bytes into a four-entry queue; the back end runs
// the scanner and holds the result in an output register. A stalled receiver
// holds a final byte at the queue head while a result is pending; bytes ahead
// of it drain, and the queue fills behind it before chars.ready drops.
//
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result
// and returns the scanner to the start of a token.
module number_with_uncertainty_scanner
    import nwus_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nwus_char_if.sink  chars,
    nwus_res_if.source results
);

    // Head of the classified-byte queue and its pop strobe.
    q_head_t head;
    logic    pop;

    nwus_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .head  (head),
        .pop   (pop)
    );

    nwus_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

@@ tb/sv/number_with_uncertainty_scanner_test.sv @@
// Self-checking testbench for the number-with-uncertainty scanner.
`timescale 1ns / 1ps

module number_with_uncertainty_scanner_test;
    import nwus_pkg::*;

    // Token bytes with a meaning to the scanner.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // The exponent stops growing once it reaches this value.
    localparam logic [63:0] EXP_LIMIT = 64'h1000_0000;

    localparam int GAP_PERCENT     = 14;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_BYTES    = 500;
    localparam int TAIL_CYCLES     = 8;

    typedef enum logic [3:0] {
        SCAN_START,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_EXP_MARK,
        SCAN_EXP_SIGN,
        SCAN_EXP_DIGITS,
        SCAN_UNC,
        SCAN_DONE
    } scan_phase_e;

    typedef struct packed {
        logic               valid_res;
        logic               negative;
        logic [63:0]        mantissa;
        logic signed [33:0] power_of_ten;
        logic [63:0]        uncertainty;
        logic [15:0]        int_digit_count;
        logic [15:0]        frac_digit_count;
        logic [15:0]        unc_digit_count;
        logic [15:0]        stop_position;
    } scan_result_t;

    // Token scanner model plus the queue of parse results still owed by the block.
    class scan_scoreboard;
        scan_phase_e     phase;
        bit              minus_sign;
        logic [63:0]     digits_value;
        logic [63:0]     exp_value;
        bit              exp_minus;
        logic [63:0]     unc_value;
        int unsigned     int_cnt;
        int unsigned     frac_cnt;
        int unsigned     unc_cnt;
        int unsigned     byte_pos;
        int unsigned     mark_pos;
        int unsigned     stop_pos;
        bit              broken;
        scan_result_t    owed_results[$];
        int              errors;

        function new();
            errors = 0;
            start_token();
        endfunction

        function void start_token();
            phase        = SCAN_START;
            minus_sign   = 1'b0;
            digits_value = '0;
            exp_value    = '0;
            exp_minus    = 1'b0;
            unc_value    = '0;
            int_cnt      = 0;
            frac_cnt     = 0;
            unc_cnt      = 0;
            byte_pos     = 0;
            mark_pos     = 0;
            stop_pos     = 0;
            broken       = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void stop_at(int unsigned pos);
            phase    = SCAN_DONE;
            stop_pos = pos;
        endfunction

        // First byte past the mantissa digits.
        function void leave_digits(logic [7:0] c, int unsigned pos);
            if (int_cnt + frac_cnt == 0)
                broken = 1'b1;
            else if (c == CH_LOWER_E || c == CH_UPPER_E)
            begin
                mark_pos = pos;
                phase    = SCAN_EXP_MARK;
            end
            else if (c == CH_LPAREN)
                phase = SCAN_UNC;
            else
                stop_at(pos);
        endfunction

        function void take_exp_digit(logic [7:0] c);
            if (exp_value < EXP_LIMIT)
                exp_value = exp_value * 10 + 64'(c - CH_ZERO);
            phase = SCAN_EXP_DIGITS;
        endfunction

        function void advance(logic [7:0] c, int unsigned pos);
            if (phase == SCAN_START)
            begin
                phase = SCAN_INT;
                if (c == CH_MINUS)
                begin
                    minus_sign = 1'b1;
                    return;
                end
                if (c == CH_PLUS)
                    return;
            end
            case (phase)
                SCAN_INT:
                    if (is_digit(c))
                    begin
                        digits_value = digits_value * 10 + 64'(c - CH_ZERO);
                        int_cnt++;
                    end
                    else if (c == CH_DOT)
                        phase = SCAN_FRAC;
                    else
                        leave_digits(c, pos);
                SCAN_FRAC:
                    if (is_digit(c))
                    begin
                        digits_value = digits_value * 10 + 64'(c - CH_ZERO);
                        frac_cnt++;
                    end
                    else
                        leave_digits(c, pos);
                SCAN_EXP_MARK:
                    if (c == CH_MINUS)
                    begin
                        exp_minus = 1'b1;
                        phase     = SCAN_EXP_SIGN;
                    end
                    else if (c == CH_PLUS)
                        phase = SCAN_EXP_SIGN;
                    else if (is_digit(c))
                        take_exp_digit(c);
                    else
                        stop_at(mark_pos);
                SCAN_EXP_SIGN:
                    if (is_digit(c))
                        take_exp_digit(c);
                    else
                        stop_at(mark_pos);
                SCAN_EXP_DIGITS:
                    if (is_digit(c))
                        take_exp_digit(c);
                    else if (c == CH_LPAREN)
                        phase = SCAN_UNC;
                    else
                        stop_at(pos);
                SCAN_UNC:
                    if (is_digit(c))
                    begin
                        unc_value = unc_value * 10 + 64'(c - CH_ZERO);
                        unc_cnt++;
                    end
                    else if (c == CH_RPAREN)
                        stop_at(pos + 1);
                    else
                        broken = 1'b1;
                default:
                    ;
            endcase
        endfunction

        // Note one accepted character request; owe a result on the final byte.
        function void note_char(logic [7:0] c, bit last);
            scan_result_t r;
            bit           ok;
            logic [63:0]  pow;

            if (byte_pos >= MAX_TOKEN_LEN)
                broken = 1'b1;
            else
            begin
                if (!broken)
                    advance(c, byte_pos);
                byte_pos++;
            end
            if (!last)
                return;

            ok = !broken;
            if (ok)
            begin
                case (phase)
                    SCAN_INT, SCAN_FRAC:
                        if (int_cnt + frac_cnt == 0)
                            ok = 1'b0;
                        else
                            stop_pos = byte_pos;
                    SCAN_EXP_MARK, SCAN_EXP_SIGN:
                        stop_pos = mark_pos;
                    SCAN_EXP_DIGITS:
                        stop_pos = byte_pos;
                    SCAN_DONE:
                        ;
                    default:
                        ok = 1'b0;
                endcase
            end

            r = '0;
            if (ok)
            begin
                pow = exp_minus ? 64'd0 - exp_value : exp_value;
                pow = pow - 64'(frac_cnt);
                r.valid_res        = 1'b1;
                r.negative         = minus_sign;
                r.mantissa         = digits_value;
                r.power_of_ten     = pow[33:0];
                r.uncertainty      = unc_value;
                r.int_digit_count  = int_cnt[15:0];
                r.frac_digit_count = frac_cnt[15:0];
                r.unc_digit_count  = unc_cnt[15:0];
                r.stop_position    = stop_pos[15:0];
            end
            owed_results.push_back(r);
            start_token();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Check one accepted result request against the oldest owed result.
        function void check_result(scan_result_t got);
            scan_result_t want;

            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("valid_res", 64'(want.valid_res), 64'(got.valid_res));
            compare_field("negative", 64'(want.negative), 64'(got.negative));
            compare_field("mantissa", want.mantissa, got.mantissa);
            compare_field("power_of_ten", 64'(unsigned'(want.power_of_ten)),
                          64'(unsigned'(got.power_of_ten)));
            compare_field("uncertainty", want.uncertainty, got.uncertainty);
            compare_field("int_digit_count", 64'(want.int_digit_count),
                          64'(got.int_digit_count));
            compare_field("frac_digit_count", 64'(want.frac_digit_count),
                          64'(got.frac_digit_count));
            compare_field("unc_digit_count", 64'(want.unc_digit_count),
                          64'(got.unc_digit_count));
            compare_field("stop_position", 64'(want.stop_position), 64'(got.stop_position));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nwus_char_if chars_if ();
    nwus_res_if  res_if ();

    number_with_uncertainty_scanner dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if)
    );

    scan_scoreboard sb;

    // Shared between the two sides: no_gaps turns off random idling on both
    // channels; hold_results asks the receiver for one long hold-off.
    bit no_gaps;
    bit hold_results;

    // Bytes of the token about to be sent.
    logic [7:0] token_bytes[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit: far above the slowest passing run, even with every stall.
    initial
    begin
        #200_000;
        $display("Regression FAIL");
        $finish;
    end

    function bit gap_now();
        return !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    endfunction

    // Offer one character request; hold it until the block takes it.
    task automatic send_byte(logic [7:0] c, bit last);
        while (gap_now())
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid      <= 1'b1;
        chars_if.character  <= c;
        chars_if.final_char <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        sb.note_char(c, last);
    endtask

    task automatic send_token();
        int n;

        n = token_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(token_bytes[i], i == n - 1);
    endtask

    task automatic send_text(string s);
        token_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            token_bytes.push_back(s[i]);
        send_token();
    endtask

    task automatic send_single(logic [7:0] c);
        token_bytes.delete();
        token_bytes.push_back(c);
        send_token();
    endtask

    // Idle the character side until every owed result has been returned.
    task automatic drain_results();
        chars_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic void add_digits(int n);
        for (int i = 0; i < n; i++)
            token_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Mostly short digit runs; now and then long enough to wrap 64 bits.
    function automatic int digit_run();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 4);
        else if (pick < 90)
            return $urandom_range(5, 12);
        return $urandom_range(13, 24);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Build one random token: mostly well formed numbers with random
    // content, plus plain noise, truncated uncertainties and stray bytes.
    function automatic void make_random_token();
        int pick;
        int spot;

        token_bytes.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 6))
                token_bytes.push_back(any_byte());
            return;
        end

        pick = $urandom_range(0, 5);
        if (pick == 0)
            token_bytes.push_back(CH_MINUS);
        else if (pick == 1)
            token_bytes.push_back(CH_PLUS);
        add_digits(digit_run());
        if ($urandom_range(0, 2) == 0)
        begin
            token_bytes.push_back(CH_DOT);
            add_digits(digit_run());
        end

        if ($urandom_range(0, 99) < 35)
        begin
            token_bytes.push_back($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
            pick = $urandom_range(0, 2);
            if (pick == 0)
                token_bytes.push_back(CH_MINUS);
            else if (pick == 1)
                token_bytes.push_back(CH_PLUS);
            // Long exponents run into the growth cap.
            add_digits($urandom_range(0, 4) == 0 ? $urandom_range(8, 12) : $urandom_range(0, 3));
        end

        if ($urandom_range(0, 99) < 35)
        begin
            token_bytes.push_back(CH_LPAREN);
            add_digits($urandom_range(0, 9) == 0 ? 22 : $urandom_range(0, 5));
            pick = $urandom_range(0, 9);
            if (pick < 8)
                token_bytes.push_back(CH_RPAREN);
            else if (pick == 8)
                token_bytes.push_back(any_byte());
        end

        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3))
                token_bytes.push_back(any_byte());

        if (token_bytes.size() == 0)
            token_bytes.push_back(any_byte());

        if ($urandom_range(0, 99) < 8)
        begin
            spot = $urandom_range(0, token_bytes.size() - 1);
            token_bytes[spot] = any_byte();
        end
    endfunction

    // Result side: accept result requests with random stalls; on request,
    // hold off for a long stretch so the block backs up into its input.
    initial
    begin
        scan_result_t got;

        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                res_if.ready <= !gap_now();
                @(posedge clk);
                if (res_if.valid && res_if.ready)
                begin
                    got.valid_res        = res_if.valid_res;
                    got.negative         = res_if.negative;
                    got.mantissa         = res_if.mantissa;
                    got.power_of_ten     = res_if.power_of_ten;
                    got.uncertainty      = res_if.uncertainty;
                    got.int_digit_count  = res_if.int_digit_count;
                    got.frac_digit_count = res_if.frac_digit_count;
                    got.unc_digit_count  = res_if.unc_digit_count;
                    got.stop_position    = res_if.stop_position;
                    sb.check_result(got);
                end
            end
        end
    end

    // Character side and run control.
    initial
    begin
        int sent;

        sb = new();
        no_gaps             = 1'b0;
        hold_results        = 1'b0;
        rst_n               = 1'b0;
        chars_if.valid      = 1'b0;
        chars_if.character  = '0;
        chars_if.final_char = 1'b0;
        res_if.ready        = 1'b0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tokens: lone question mark, lone point, bare sign, signed
        // fraction, exponent marks with no digits (backs off to the 'e'),
        // uncertainty cut short or closed by a wrong byte, closed
        // uncertainty, and the two byte extremes.
        send_text("?");
        send_text(".");
        send_text("-");
        send_text("-1.5");
        send_text("2e");
        send_text("3E+x");
        send_text("9(4");
        send_text("1(2x");
        send_text("8(5)");
        send_single(8'hFF);
        send_single(8'h00);
        drain_results();

        // Random tokens, with one stretch where neither side idles.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            no_gaps = (sent >= 200 && sent < 330);
            make_random_token();
            sent += token_bytes.size();
            send_token();
        end
        no_gaps = 1'b0;

        // Stall the results for a long stretch while tokens keep coming, so
        // the queue fills and character requests back up.
        hold_results = 1'b1;
        repeat (12)
        begin
            make_random_token();
            send_token();
        end
        drain_results();

        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
